// ----- hw/rtl/delayed_spike_message_table_defines.svh -----
// Assertion macros used by the checker file of the message table
`ifndef DELAYED_SPIKE_MESSAGE_TABLE_DEFINES_SVH
`define DELAYED_SPIKE_MESSAGE_TABLE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define DSMT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define DSMT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/dsmt_pkg.sv -----
// Types and constants of the delayed spike message table
`default_nettype none

package dsmt_pkg;

  localparam int unsigned ProjW   = 4;
  localparam int unsigned UnitW   = 16;
  localparam int unsigned KindW   = 8;
  localparam int unsigned DelayW  = 4;
  localparam int unsigned DelayAll = (1 << DelayW) - 1;

  typedef enum logic [1:0] {
    STAT_DELIVERED = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_DROPPED   = 2'd2
  } status_e;

  typedef enum logic {
    MODE_SEND = 1'b0,
    MODE_TICK = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  // one table slot
  typedef struct packed {
    logic [ProjW-1:0]  proj;
    logic [UnitW-1:0]  src;
    logic [UnitW-1:0]  dest;
    logic [KindW-1:0]  kind;
    logic [DelayW-1:0] dly;
    logic [DelayW-1:0] cnt;
  } slot_t;

  // one result item
  typedef struct packed {
    status_e           status;
    logic [ProjW-1:0]  proj;
    logic [UnitW-1:0]  src;
    logic [UnitW-1:0]  dest;
    logic [KindW-1:0]  kind;
    logic [DelayW-1:0] dly;
    logic              last;
  } res_t;

  typedef struct packed {
    logic shift;
    logic write;
  } cell_ctrl_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/delayed_spike_message_table.sv -----
// Delayed spike message table: top level with slot ring, free stack and control
//
// Input channel (in_valid_i / in_stall_o) carries one item: mode_i selects a
// send (store a message) or a tick (age every stored message by one).
// Output channel (out_valid_o / out_stall_i) carries result items; last_o
// marks the final result of the item that caused it.
// A send gives no result, unless the table is full: then the finishing state
// puts one dropped-status result into the output register. A tick rotates
// the ring of SLOTS cells one slot per cycle past the head cell while no due
// message waits for room, then passes through the finishing state. Every
// message of nonzero type that comes due is sent in slot order; a tick with
// nothing due gives one empty result.
// Only one item is worked on at a time: in_stall_o is high until the item's
// last result sits in the output register.
// When the receiver stalls, the output register holds its item and the ring
// pauses on the next due message until room is free.
// Reset empties the table and the free stack and sets the delay to 1.
// cfg_we_i / cfg_wdata_i write the delay register; write only while idle.
`default_nettype none

module delayed_spike_message_table #(
  parameter int unsigned SLOTS       = 32,
  parameter int unsigned PROJECTIONS = 16,
  parameter int unsigned MAX_DELAY   = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [3:0]  proj_i,
  input  logic [15:0] src_mcu_i,
  input  logic [15:0] dst_unit_i,
  input  logic [7:0]  msg_type_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [3:0]  proj_res_o,
  output logic [15:0] src_mcu_res_o,
  output logic [15:0] dst_unit_res_o,
  output logic [7:0]  msg_type_res_o,
  output logic [3:0]  delay_o,
  output logic        last_o
);

  localparam int unsigned SlotW     = $clog2(SLOTS);
  localparam int unsigned CntW      = $clog2(SLOTS + 1);
  localparam int unsigned DlyCapInt =
    (MAX_DELAY > dsmt_pkg::DelayAll) ? dsmt_pkg::DelayAll : MAX_DELAY;
  localparam int unsigned ProjN     = 1 << dsmt_pkg::ProjW;

  typedef logic [SlotW-1:0]            idx_t;
  typedef logic [CntW-1:0]             cnt_t;
  typedef logic [dsmt_pkg::DelayW-1:0] dly_t;
  typedef logic [dsmt_pkg::ProjW-1:0]  proj_t;

  localparam dly_t DlyCap = dly_t'(DlyCapInt);

  // projection folding table
  proj_t proj_tbl [ProjN];
  for (genvar g = 0; g < ProjN; g++) begin : g_proj
    localparam proj_t ProjMod = proj_t'(g % PROJECTIONS);
    assign proj_tbl[g] = ProjMod;
  end

  dsmt_pkg::state_e  state_q, state_d;
  cnt_t              fill_cnt_q, fill_cnt_d;
  cnt_t              free_cnt_q, free_cnt_d;
  idx_t              scan_idx_q, scan_idx_d;
  logic              hold_vld_q, hold_vld_d;
  dsmt_pkg::status_e fin_stat_q, fin_stat_d;
  logic              out_vld_q, out_vld_d;
  dly_t              dly_q, dly_d;
  dsmt_pkg::res_t    hold_q, hold_d;
  dsmt_pkg::res_t    out_q, out_d;

  dsmt_pkg::slot_t      ent [SLOTS];
  dsmt_pkg::slot_t      head_next;
  dsmt_pkg::slot_t      wr_data;
  dsmt_pkg::cell_ctrl_t cell_ctrl [SLOTS];
  dsmt_pkg::stk_ctrl_t  stk_ctrl;
  idx_t                 stk_top;
  idx_t                 wr_slot;

  logic accept, table_full, send_ok, out_free, step_ok, shift_en, scan_last;
  logic in_range, hit, fire, hold_load, out_load;
  dly_t dly_sat, cnt_dec;
  dsmt_pkg::res_t head_res;

  // ---------------------------------------------------------------- datapath
  assign out_free   = !out_vld_q || !out_stall_i;
  assign table_full = (free_cnt_q == '0) && (fill_cnt_q == cnt_t'(SLOTS));
  assign dly_sat    = (dly_q > DlyCap) ? DlyCap : dly_q;
  assign wr_slot    = (free_cnt_q != '0) ? stk_top : fill_cnt_q[SlotW-1:0];

  assign in_range  = cnt_t'(scan_idx_q) < fill_cnt_q;
  assign hit       = in_range && (ent[0].cnt != '0);
  assign cnt_dec   = ent[0].cnt - dly_t'(1);
  assign fire      = hit && (cnt_dec == '0) && (ent[0].kind != '0);
  assign scan_last = scan_idx_q == idx_t'(SLOTS - 1);
  // a due message needs room only when an earlier one is still held back
  assign step_ok   = !(fire && hold_vld_q) || out_free;

  always_comb begin
    head_next = ent[0];
    if (hit) begin
      head_next.cnt = cnt_dec;
    end
    if (fire) begin
      head_next.kind = '0;
    end
  end

  always_comb begin
    head_res.status = dsmt_pkg::STAT_DELIVERED;
    head_res.proj   = ent[0].proj;
    head_res.src    = ent[0].src;
    head_res.dest   = ent[0].dest;
    head_res.kind   = ent[0].kind;
    head_res.dly    = ent[0].dly;
    head_res.last   = 1'b0;
  end

  always_comb begin
    wr_data.proj = proj_tbl[proj_i];
    wr_data.src  = src_mcu_i;
    wr_data.dest = dst_unit_i;
    wr_data.kind = msg_type_i;
    wr_data.dly  = dly_sat;
    wr_data.cnt  = dly_sat;
  end

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    dsmt_pkg::slot_t nb;

    if (k == SLOTS - 1) begin : g_wrap
      assign nb = head_next;
    end else begin : g_link
      assign nb = ent[k+1];
    end

    assign cell_ctrl[k].shift = shift_en;
    assign cell_ctrl[k].write = send_ok && (wr_slot == idx_t'(k));

    dsmt_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (cell_ctrl[k]),
      .wr_data_i (wr_data),
      .nb_i      (nb),
      .ent_o     (ent[k])
    );
  end

  dsmt_stack #(
    .DEPTH (SLOTS)
  ) u_stack (
    .clk_i       (clk_i),
    .ctrl_i      (stk_ctrl),
    .push_data_i (scan_idx_q),
    .top_o       (stk_top)
  );

  // ------------------------------------------------------------ next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dsmt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (mode_i == dsmt_pkg::MODE_TICK) begin
            state_d = dsmt_pkg::S_SCAN;
          end else if (table_full) begin
            state_d = dsmt_pkg::S_FINISH;
          end
        end
      end
      dsmt_pkg::S_SCAN: begin
        if (step_ok && scan_last) begin
          state_d = dsmt_pkg::S_FINISH;
        end
      end
      dsmt_pkg::S_FINISH: begin
        if (out_free) begin
          state_d = dsmt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dsmt_pkg::S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------- outputs
  always_comb begin
    accept        = 1'b0;
    send_ok       = 1'b0;
    shift_en      = 1'b0;
    hold_load     = 1'b0;
    out_load      = 1'b0;
    out_d         = hold_q;
    stk_ctrl.push = 1'b0;
    stk_ctrl.pop  = 1'b0;
    fill_cnt_d    = fill_cnt_q;
    free_cnt_d    = free_cnt_q;
    scan_idx_d    = scan_idx_q;
    hold_vld_d    = hold_vld_q;
    fin_stat_d    = fin_stat_q;
    hold_d        = hold_q;

    case (state_q)
      dsmt_pkg::S_IDLE: begin
        accept = in_valid_i;
        if (accept) begin
          scan_idx_d = '0;
          if (mode_i == dsmt_pkg::MODE_TICK) begin
            fin_stat_d = dsmt_pkg::STAT_EMPTY;
          end else if (table_full) begin
            fin_stat_d = dsmt_pkg::STAT_DROPPED;
          end else begin
            send_ok = 1'b1;
            if (free_cnt_q != '0) begin
              stk_ctrl.pop = 1'b1;
              free_cnt_d   = free_cnt_q - cnt_t'(1);
            end else begin
              fill_cnt_d = fill_cnt_q + cnt_t'(1);
            end
          end
        end
      end
      dsmt_pkg::S_SCAN: begin
        shift_en = step_ok;
        if (step_ok) begin
          scan_idx_d = scan_idx_q + idx_t'(1);
          if (fire) begin
            hold_load  = 1'b1;
            hold_d     = head_res;
            hold_vld_d = 1'b1;
            // the held message was not the last one after all
            out_load   = hold_vld_q;
            out_d      = hold_q;
            if (free_cnt_q < cnt_t'(SLOTS)) begin
              stk_ctrl.push = 1'b1;
              free_cnt_d    = free_cnt_q + cnt_t'(1);
            end
          end
        end
      end
      dsmt_pkg::S_FINISH: begin
        if (out_free) begin
          out_load   = 1'b1;
          hold_vld_d = 1'b0;
          if (hold_vld_q) begin
            out_d      = hold_q;
            out_d.last = 1'b1;
          end else begin
            out_d.status = fin_stat_q;
            out_d.proj   = '0;
            out_d.src    = '0;
            out_d.dest   = '0;
            out_d.kind   = '0;
            out_d.dly    = '0;
            out_d.last   = 1'b1;
          end
        end
      end
      default: begin
        accept = 1'b0;
      end
    endcase

    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end

    dly_d = cfg_we_i ? cfg_wdata_i : dly_q;
  end

  // ------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dsmt_pkg::S_IDLE;
      fill_cnt_q <= '0;
      free_cnt_q <= '0;
      scan_idx_q <= '0;
      hold_vld_q <= 1'b0;
      fin_stat_q <= dsmt_pkg::STAT_EMPTY;
      out_vld_q  <= 1'b0;
      dly_q      <= dly_t'(1);
    end else begin
      state_q    <= state_d;
      fill_cnt_q <= fill_cnt_d;
      free_cnt_q <= free_cnt_d;
      scan_idx_q <= scan_idx_d;
      hold_vld_q <= hold_vld_d;
      fin_stat_q <= fin_stat_d;
      out_vld_q  <= out_vld_d;
      dly_q      <= dly_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_load) begin
      hold_q <= hold_d;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign in_stall_o     = (state_q != dsmt_pkg::S_IDLE);
  assign out_valid_o    = out_vld_q;
  assign status_o       = out_q.status;
  assign proj_res_o     = out_q.proj;
  assign src_mcu_res_o  = out_q.src;
  assign dst_unit_res_o = out_q.dest;
  assign msg_type_res_o = out_q.kind;
  assign delay_o        = out_q.dly;
  assign last_o         = out_q.last;

endmodule

`default_nettype wire

// ----- hw/rtl/dsmt_cell.sv -----
// One slot cell of the rotating slot ring
`default_nettype none

module dsmt_cell (
  input  logic                 clk_i,
  input  dsmt_pkg::cell_ctrl_t ctrl_i,
  input  dsmt_pkg::slot_t      wr_data_i,
  input  dsmt_pkg::slot_t      nb_i,
  output dsmt_pkg::slot_t      ent_o
);

  dsmt_pkg::slot_t ent_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.write) begin
      ent_q <= wr_data_i;
    end else if (ctrl_i.shift) begin
      ent_q <= nb_i;
    end
  end

  assign ent_o = ent_q;

endmodule

`default_nettype wire

// ----- hw/rtl/dsmt_stack.sv -----
// Free-slot LIFO built as a shifting chain, top at entry 0
`default_nettype none

module dsmt_stack #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                       clk_i,
  input  dsmt_pkg::stk_ctrl_t        ctrl_i,
  input  logic [$clog2(DEPTH)-1:0]   push_data_i,
  output logic [$clog2(DEPTH)-1:0]   top_o
);

  typedef logic [$clog2(DEPTH)-1:0] idx_t;

  idx_t ent_q [DEPTH];
  idx_t ent_d [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_ent
    idx_t from_up;
    idx_t from_down;

    if (k == 0) begin : g_top
      assign from_up = push_data_i;
    end else begin : g_mid
      assign from_up = ent_q[k-1];
    end

    if (k == DEPTH - 1) begin : g_bot
      assign from_down = ent_q[k];
    end else begin : g_nbot
      assign from_down = ent_q[k+1];
    end

    always_comb begin
      if (ctrl_i.push) begin
        ent_d[k] = from_up;
      end else if (ctrl_i.pop) begin
        ent_d[k] = from_down;
      end else begin
        ent_d[k] = ent_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      ent_q[k] <= ent_d[k];
    end
  end

  assign top_o = ent_q[0];

endmodule

`default_nettype wire

// ----- hw/rtl/dsmt_checker.sv -----
// Port-level checks of the message table, bound to the top level
`default_nettype none
`include "delayed_spike_message_table_defines.svh"

module dsmt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        mode_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  status_o,
  input wire logic [15:0] src_mcu_res_o,
  input wire logic [7:0]  msg_type_res_o,
  input wire logic        last_o
);

  // a stalled result item holds
  `DSMT_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(status_o) && $stable(src_mcu_res_o) && $stable(last_o),
    "stalled result item changed")

  // status-only results always close their item
  `DSMT_ASSERT_IMP(a_status_last,
    out_valid_o && (status_o != dsmt_pkg::STAT_DELIVERED), last_o,
    "status result without last")

  // messages of type zero are never delivered
  `DSMT_ASSERT_IMP(a_deliver_kind,
    out_valid_o && (status_o == dsmt_pkg::STAT_DELIVERED), msg_type_res_o != 8'd0,
    "delivered message has type zero")

  // a tick keeps the input stalled while the ring is scanned
  `DSMT_ASSERT_NXT(a_tick_busy,
    in_valid_i && !in_stall_o && (mode_i == dsmt_pkg::MODE_TICK), in_stall_o,
    "input taken during a tick scan")

endmodule

bind delayed_spike_message_table dsmt_checker u_dsmt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .mode_i         (mode_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .src_mcu_res_o  (src_mcu_res_o),
  .msg_type_res_o (msg_type_res_o),
  .last_o         (last_o)
);

`default_nettype wire
